FILE: rtl/ita_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
// Used by the front converter, the entry queue, the character emitter and the top level.
// No dependencies.
package ita_pkg;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int DIG_W   = 4;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * DIG_W;

    // Double dabble schedule: four binary bits folded in per cycle.
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);

    // Default depth of the queue between the converter and the emitter.
    localparam int QUEUE_DEPTH_DEF = 2;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // One converted value waiting to be emitted.
    typedef struct packed {
        logic             neg;
        logic [LEN_W-1:0] ndig;
        logic [BCD_W-1:0] bcd;
    } ita_entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } front_state_t;

    typedef enum logic {
        BK_LOAD,
        BK_EMIT
    } back_state_t;

endpackage

FILE: rtl/ita_front.sv
// Front part: accepts a value request, forms its magnitude and converts it to BCD.
// Double dabble, four bits per cycle; the finished entry is pushed into the queue.
// Depends on ita_pkg.
module ita_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ita_pkg::VALUE_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       q_full,
    output logic                       q_push,
    output ita_pkg::ita_entry_t        q_entry
);
    import ita_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CONV_STEPS - 1);

    front_state_t         state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic                 accept;
    logic                 in_neg;
    logic [LEN_W-1:0]     ndig;

    // One double dabble bit: correct every digit of five or more, then shift in.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd_in,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd_in;
        for (int d = 0; d < DIGITS; d++) begin
            if (adj[d*DIG_W +: DIG_W] >= DIG_W'(5)) begin
                adj[d*DIG_W +: DIG_W] = adj[d*DIG_W +: DIG_W] + DIG_W'(3);
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    assign accept = s_tvalid && s_tready;
    assign in_neg = s_tuser && s_tdata[VALUE_W-1];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (accept) state_next = FR_CONV;
            end
            FR_CONV: begin
                if (cnt_reg == LAST_STEP) state_next = FR_PUSH;
            end
            FR_PUSH: begin
                if (!q_full) state_next = FR_IDLE;
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            FR_IDLE: s_tready = 1'b1;
            FR_PUSH: q_push   = !q_full;
            default: begin
                s_tready = 1'b0;
                q_push   = 1'b0;
            end
        endcase
    end

    // Datapath: load the magnitude, then fold four bits per cycle into the BCD word.
    always_comb begin
        logic [BCD_W-1:0] b;
        mag_next = mag_reg;
        neg_next = neg_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        b        = bcd_reg;
        if (accept) begin
            neg_next = in_neg;
            mag_next = in_neg ? (VALUE_W'(0) - s_tdata) : s_tdata;
            bcd_next = '0;
            cnt_next = '0;
        end else if (state_reg == FR_CONV) begin
            for (int j = 0; j < BITS_PER_STEP; j++) begin
                b = dd_step(b, mag_reg[VALUE_W-1-j]);
            end
            bcd_next = b;
            mag_next = {mag_reg[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            cnt_next = cnt_reg + STEP_W'(1);
        end
    end

    // Digit count: position of the highest nonzero digit, at least one.
    always_comb begin
        ndig = LEN_W'(1);
        for (int d = 1; d < DIGITS; d++) begin
            if (bcd_reg[d*DIG_W +: DIG_W] != '0) ndig = LEN_W'(d + 1);
        end
    end

    assign q_entry.neg  = neg_reg;
    assign q_entry.ndig = ndig;
    assign q_entry.bcd  = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

endmodule

FILE: rtl/ita_fifo.sv
// Short queue of converted entries between the front converter and the emitter.
// Register storage with wrapping pointers and an occupancy count.
// Depends on ita_pkg.
module ita_fifo #(
    parameter int DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ita_pkg::ita_entry_t wr_entry,
    input  logic                pop,
    output ita_pkg::ita_entry_t rd_entry,
    output logic                full,
    output logic                empty
);
    import ita_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ita_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    // Pointer and count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

FILE: rtl/ita_back.sv
// Back part: pops a converted entry and emits its text one character per request.
// Sign first when negative, then digits from the most significant down.
// Depends on ita_pkg.
module ita_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  ita_pkg::ita_entry_t       q_entry,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ita_pkg::CHAR_W-1:0] m_char,
    output logic [ita_pkg::LEN_W-1:0]  m_len,
    output logic                      m_tlast
);
    import ita_pkg::*;

    back_state_t        state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_last_reg, out_last_next;
    logic               slot_free;
    logic               emit;
    logic               emit_last;
    logic [DIG_W-1:0]   digit;

    assign slot_free = !out_valid_reg || m_tready;
    assign digit     = bcd_reg[{idx_reg, 2'b00} +: DIG_W];
    assign emit_last = !neg_reg && (idx_reg == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD: begin
                if (!q_empty) state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (slot_free && emit_last) state_next = BK_LOAD;
            end
            default: state_next = BK_LOAD;
        endcase
    end

    // Control outputs.
    always_comb begin
        q_pop = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            BK_LOAD: q_pop = !q_empty;
            BK_EMIT: emit  = slot_free;
            default: begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // Run registers and the output register.
    always_comb begin
        neg_next       = neg_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        if (q_pop) begin
            neg_next = q_entry.neg;
            len_next = q_entry.ndig + LEN_W'(q_entry.neg);
            idx_next = q_entry.ndig - LEN_W'(1);
            bcd_next = q_entry.bcd;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            out_len_next   = len_reg;
            out_last_next  = emit_last;
            if (neg_reg) begin
                out_char_next = CHAR_MINUS;
                neg_next      = 1'b0;
            end else begin
                out_char_next = CHAR_ZERO + CHAR_W'(digit);
                idx_next      = idx_reg - LEN_W'(1);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_char   = out_char_reg;
    assign m_len    = out_len_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_LOAD;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
        end
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: rtl/int_to_decimal_ascii_unit.sv
// Integer to decimal ASCII converter: 32-bit value in, one character per output request.
// An accepted value is converted by the front part, pushed into the queue, popped by the
// emitter and registered in the output register before its first character appears.
// The converter runs 8 double dabble steps of four bits each per value and takes a new value
// once its entry is pushed, so it can convert while the emitter still sends earlier text.
// Reset: synchronous active-low aresetn clears the state machines, queue and output valid.
module int_to_decimal_ascii_unit #(
    parameter int QUEUE_DEPTH = ita_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] value_bits
    input  logic        s_tuser,  // [0] is_signed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [7:0] char_code, [11:8] text_length, [15:12] zero
    output logic        m_tlast   // last_char
);
    import ita_pkg::*;

    ita_entry_t        push_entry;
    ita_entry_t        pop_entry;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [CHAR_W-1:0] m_char;
    logic [LEN_W-1:0]  m_len;

    // Converter.
    ita_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // Queue of converted values.
    ita_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (push_entry),
        .pop      (q_pop),
        .rd_entry (pop_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Character emitter.
    ita_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_char),
        .m_len    (m_len),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {4'd0, m_len, m_char};

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty) else $error("queue read while empty");

    // Every character is a minus sign or a decimal digit, with a legal length.
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_char == CHAR_MINUS) ||
                      ((m_char >= CHAR_ZERO) && (m_char <= CHAR_ZERO + 8'd9))) &&
                     (m_len >= 4'd1) && (m_len <= 4'd11))
        else $error("illegal character or length");

    // A minus sign never ends a run.
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_char == CHAR_MINUS)) |-> !m_tlast)
        else $error("run ended on a minus sign");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for int_to_decimal_ascii_unit: signed and unsigned words go in, and every
// emitted character, its text length and its last flag are checked against a local itoa predictor.
// Depends on the ita_pkg package and the int_to_decimal_ascii_unit RTL.
module testbench;
    import ita_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 309;
    localparam int IDLE_PERCENT = 38;
    localparam int QUIET_FROM   = 1500;
    localparam int QUIET_TO     = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 21;

    // One conversion request: the word and its signed flag, flag in the low bit.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_signed;
    } word_req_t;

    // One expected output character.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic              last;
    } text_char_t;

    // Edge cases: zero, digit-count boundaries, the most negative value, all ones.
    localparam logic [VALUE_W:0] DIRECTED [N_DIRECTED] = '{
        {32'd0, 1'b0},          {32'd0, 1'b1},          {32'd1, 1'b0},
        {32'd9, 1'b1},          {32'd10, 1'b0},         {32'd99, 1'b1},
        {32'd100, 1'b0},        {32'd12345, 1'b1},      {32'd999999999, 1'b0},
        {32'd1000000000, 1'b0}, {32'h7FFFFFFF, 1'b1},   {32'h7FFFFFFF, 1'b0},
        {32'h80000000, 1'b1},   {32'h80000000, 1'b0},   {32'hFFFFFFFF, 1'b1},
        {32'hFFFFFFFF, 1'b0},   {32'hFFFFFFF6, 1'b1},   {32'hC4653600, 1'b1},
        {32'hC4653600, 1'b0},   {32'hAAAAAAAA, 1'b0},   {32'h55555555, 1'b1}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // [31:0] value_bits
    logic        s_tuser  = 1'b0;  // [0] is_signed
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;  // [7:0] char_code, [11:8] text_length, [15:12] zero
    logic        m_tlast;  // last_char

    word_req_t  pending_words [$];
    text_char_t expected_text [$];
    word_req_t  next_word;
    logic       req_taken      = 1'b0;
    int         words_accepted = 0;
    int         total_words    = 0;
    int         cycle_count    = 0;
    int         mismatches     = 0;

    int_to_decimal_ascii_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Expected characters of one word, most significant first, with a sign when negative.
    function automatic void predict_text(input logic [VALUE_W-1:0] bits, input logic sgn);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [DIG_W-1:0]   digit_buf [DIGITS];
        int                 ndig;
        logic [LEN_W-1:0]   len;
        text_char_t         c;
        neg  = sgn && bits[VALUE_W-1];
        mag  = neg ? -bits : bits;
        ndig = 0;
        do begin
            digit_buf[ndig] = DIG_W'(mag % 10);
            mag = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < DIGITS);
        len = LEN_W'(ndig + (neg ? 1 : 0));
        if (neg) begin
            c.code   = CHAR_MINUS;
            c.length = len;
            c.last   = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = ndig; i > 0; i--) begin
            c.code   = CHAR_ZERO + CHAR_W'(digit_buf[i-1]);
            c.length = len;
            c.last   = (i == 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // Random words spread over all text lengths, negatives and values at and beside powers of ten.
    function automatic word_req_t random_word();
        word_req_t w;
        int        n;
        n = $urandom_range(9, 1);
        w.is_signed = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: w.value = $urandom;
            1: w.value = $urandom_range(pow10(n) - 1);
            2: begin
                w.value     = -$urandom_range(pow10(n));
                w.is_signed = 1'b1;
            end
            default: w.value = pow10(n) + $urandom_range(2) - 1;
        endcase
        return w;
    endfunction

    // Random idle decision, off inside the quiet window.
    function automatic logic idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    function automatic void check_char();
        text_char_t want;
        if (expected_text.size() == 0) begin
            $error("unexpected character %0d with no value pending", m_tdata[CHAR_W-1:0]);
            mismatches++;
            return;
        end
        want = expected_text.pop_front();
        if (m_tdata[CHAR_W-1:0] !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, m_tdata[CHAR_W-1:0]);
            mismatches++;
        end
        if (m_tdata[CHAR_W +: LEN_W] !== want.length) begin
            $error("text_length: expected %0d, actual %0d", want.length,
                   m_tdata[CHAR_W +: LEN_W]);
            mismatches++;
        end
        if (m_tlast !== want.last) begin
            $error("last_char: expected %0d, actual %0d", want.last, m_tlast);
            mismatches++;
        end
        if (m_tdata[15:CHAR_W+LEN_W] !== '0) begin
            $error("tdata padding: expected 0, actual %0h", m_tdata[15:CHAR_W+LEN_W]);
            mismatches++;
        end
    endfunction

    // Input driver: a new request goes out once the previous one was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                if (pending_words.size() != 0 && !idle_now()) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.value;
                    s_tuser  <= next_word.is_signed;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
    end

    // Monitor: predict on every accepted request, check every accepted character.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        req_taken   <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_text(s_tdata, s_tuser);
            words_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            check_char();
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus setup, reset, and end of run.
    initial begin
        for (int i = 0; i < N_DIRECTED; i++) begin
            pending_words.push_back(word_req_t'(DIRECTED[i]));
        end
        repeat (RANDOM_ITEMS) pending_words.push_back(random_word());
        total_words = pending_words.size();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        while (words_accepted != total_words) @(negedge aclk);
        while (expected_text.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ita_pkg.sv
rtl/ita_front.sv
rtl/ita_fifo.sv
rtl/ita_back.sv
rtl/int_to_decimal_ascii_unit.sv
verif/testbench.sv
